// File: hdl/bll_pkg.sv
// Shared types and codes for the bounded linked list engine.
// Used by the control unit, the storage cells and the top level.
package bll_pkg;

   // Request kinds, carried on req_tuser
   typedef enum logic [2:0] {
      K_INS_FRONT = 3'd0,
      K_INS_LAST  = 3'd1,
      K_INS_AFTER = 3'd2,
      K_DEL_FRONT = 3'd3,
      K_DEL_LAST  = 3'd4,
      K_DEL_VALUE = 3'd5
   } kind_type;

   // Result status codes, carried on rsp_tuser
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_EMPTY    = 3'd1;
   localparam logic [2:0] ST_RANGE    = 3'd2;
   localparam logic [2:0] ST_NOTFOUND = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;

   localparam int VALUE_W = 32;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INS,
      CELL_DEL
   } cell_op_type;

   // Command broadcast to every cell of the chain
   typedef struct packed {
      cell_op_type op;
      logic        scan_load;
      logic        scan_shift;
   } cell_cmd_type;

endpackage

// File: hdl/bll_cell.sv
// One storage cell of the list chain: a list entry and a scan stage.
// Depends on bll_pkg; neighbours are wired by the top level.
module bll_cell import bll_pkg::*; #(
   parameter int CW  = 5,
   parameter int IDX = 0
) (
   input  logic                      clock,
   input  cell_cmd_type              cmd,
   input  logic [CW-1:0]             pos,
   input  logic signed [VALUE_W-1:0] key,
   input  logic signed [VALUE_W-1:0] left_value,
   input  logic signed [VALUE_W-1:0] right_value,
   input  logic signed [VALUE_W-1:0] right_scan,
   output logic signed [VALUE_W-1:0] value,
   output logic signed [VALUE_W-1:0] scan
);

   localparam logic [CW-1:0] MY_IDX = CW'(IDX);

   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic signed [VALUE_W-1:0] scan_ff, scan_in;

   always_comb begin
      value_in = value_ff;
      case (cmd.op)
         CELL_INS: begin
            // open a gap at pos: later entries move one place up
            if (MY_IDX == pos) begin
               value_in = key;
            end else if (MY_IDX > pos) begin
               value_in = left_value;
            end
         end
         CELL_DEL: begin
            if (MY_IDX >= pos) begin
               value_in = right_value;
            end
         end
         default: value_in = value_ff;
      endcase
   end

   always_comb begin
      scan_in = scan_ff;
      if (cmd.scan_load) begin
         scan_in = value_ff;
      end else if (cmd.scan_shift) begin
         scan_in = right_scan;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      scan_ff  <= scan_in;
   end

   assign value = value_ff;
   assign scan  = scan_ff;

endmodule

// File: hdl/bll_ctrl.sv
// Control unit: request decode, occupancy, scan sequencing and result register.
// Depends on bll_pkg; drives the command broadcast to the cell chain.
module bll_ctrl import bll_pkg::*; #(
   parameter int CAPACITY = 16,
   parameter int CW       = 5
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [2:0]                req_kind,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic [3:0]                req_position,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [2:0]                rsp_status,
   output logic signed [VALUE_W-1:0] rsp_value,
   input  logic signed [VALUE_W-1:0] front_value,
   input  logic signed [VALUE_W-1:0] scan_head,
   output cell_cmd_type              cell_cmd,
   output logic [CW-1:0]             cell_pos
);

   localparam int PW = (CW > 4) ? CW : 4;
   localparam logic [CW-1:0] ONE = CW'(1);

   state_type                 state_ff, state_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [CW-1:0]             idx_ff, idx_in;
   kind_type                  kind_ff, kind_in;
   logic signed [VALUE_W-1:0] key_ff, key_in;
   logic [2:0]                res_status_ff, res_status_in;
   logic signed [VALUE_W-1:0] res_value_ff, res_value_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [2:0]                rsp_status_ff, rsp_status_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;

   logic     accept;
   logic     empty;
   logic     full;
   logic     out_free;
   logic     at_tail;
   logic     hit;
   logic     scan_done;
   logic     needs_scan;
   kind_type kind;

   assign kind       = kind_type'(req_kind);
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign empty      = (count_ff == '0);
   assign full       = (count_ff == CW'(CAPACITY));
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign at_tail    = (idx_ff == count_ff - ONE);
   assign hit        = (scan_head == key_ff);
   assign scan_done  = (kind_ff == K_DEL_LAST) ? at_tail : (hit || at_tail);
   assign needs_scan = !empty && ((kind == K_DEL_LAST) || (kind == K_DEL_VALUE));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = needs_scan ? S_SCAN : S_FINISH;
            end
         end
         S_SCAN: begin
            if (scan_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and cell commands
   always_comb begin
      cell_cmd      = '{op: CELL_HOLD, scan_load: 1'b0, scan_shift: 1'b0};
      cell_pos      = '0;
      count_in      = count_ff;
      idx_in        = idx_ff;
      kind_in       = kind_ff;
      key_in        = key_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               kind_in       = kind;
               key_in        = req_value;
               idx_in        = '0;
               res_status_in = ST_OK;
               res_value_in  = '0;
               unique case (kind)
                  K_INS_FRONT, K_INS_LAST: begin
                     if (full) begin
                        res_status_in = ST_FULL;
                     end else begin
                        cell_cmd.op  = CELL_INS;
                        cell_pos     = (kind == K_INS_FRONT) ? '0 : count_ff;
                        count_in     = count_ff + ONE;
                        res_value_in = req_value;
                     end
                  end
                  K_INS_AFTER: begin
                     if (empty) begin
                        res_status_in = ST_EMPTY;
                     end else if (full) begin
                        res_status_in = ST_FULL;
                     end else if (PW'(req_position) >= PW'(count_ff)) begin
                        res_status_in = ST_RANGE;
                     end else begin
                        cell_cmd.op  = CELL_INS;
                        cell_pos     = CW'(req_position) + ONE;
                        count_in     = count_ff + ONE;
                        res_value_in = req_value;
                     end
                  end
                  K_DEL_FRONT: begin
                     if (empty) begin
                        res_status_in = ST_EMPTY;
                     end else begin
                        cell_cmd.op  = CELL_DEL;
                        cell_pos     = '0;
                        count_in     = count_ff - ONE;
                        res_value_in = front_value;
                     end
                  end
                  K_DEL_LAST, K_DEL_VALUE: begin
                     if (empty) begin
                        res_status_in = ST_EMPTY;
                     end else begin
                        cell_cmd.scan_load = 1'b1;
                     end
                  end
                  default: begin
                     // unused kinds leave the list alone
                     res_status_in = ST_OK;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (kind_ff == K_DEL_LAST) begin
               if (at_tail) begin
                  count_in     = count_ff - ONE;
                  res_value_in = scan_head;
               end else begin
                  cell_cmd.scan_shift = 1'b1;
                  idx_in              = idx_ff + ONE;
               end
            end else if (hit) begin
               // close the gap at the first match
               cell_cmd.op  = CELL_DEL;
               cell_pos     = idx_ff;
               count_in     = count_ff - ONE;
               res_value_in = key_ff;
            end else if (at_tail) begin
               res_status_in = ST_NOTFOUND;
            end else begin
               cell_cmd.scan_shift = 1'b1;
               idx_in              = idx_ff + ONE;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = res_value_ff;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_value  = rsp_value_ff;

endmodule

// File: hdl/bounded_linked_list_engine.sv
// Bounded linked list engine: a chain of CAPACITY cells kept in list order.
// Inserts and front deletes go from acceptance to the finish state; delete last and
// delete by value pass the scan state first, where the scan chain moves one entry per
// cycle towards cell 0 until the tail or, for delete by value, the first match. One
// request at a time. Synchronous reset empties the list and clears rsp_tvalid; cell
// contents keep whatever they held, entries beyond the count are never read.
module bounded_linked_list_engine import bll_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [31:0] value, [35:32] position, [39:36] zero
   input  logic [2:0]  req_tuser,   // [2:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] result_value
   output logic [2:0]  rsp_tuser    // [2:0] status
);

   localparam int CW = $clog2(CAPACITY + 1);

   cell_cmd_type              cell_cmd;
   logic [CW-1:0]             cell_pos;
   logic signed [VALUE_W-1:0] req_value;
   logic signed [VALUE_W-1:0] rsp_value;
   logic signed [VALUE_W-1:0] cell_value [CAPACITY];
   logic signed [VALUE_W-1:0] cell_scan  [CAPACITY];
   logic signed [VALUE_W-1:0] left_value [CAPACITY];
   logic signed [VALUE_W-1:0] right_value[CAPACITY];
   logic signed [VALUE_W-1:0] right_scan [CAPACITY];

   assign req_value = req_tdata[31:0];
   assign rsp_tdata = rsp_value;

   bll_ctrl #(
      .CAPACITY(CAPACITY),
      .CW      (CW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_kind    (req_tuser),
      .req_value   (req_value),
      .req_position(req_tdata[35:32]),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_status  (rsp_tuser),
      .rsp_value   (rsp_value),
      .front_value (cell_value[0]),
      .scan_head   (cell_scan[0]),
      .cell_cmd    (cell_cmd),
      .cell_pos    (cell_pos)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign left_value[i] = req_value;
      end else begin : g_mid
         assign left_value[i] = cell_value[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_value[i] = cell_value[i];
         assign right_scan[i]  = cell_scan[i];
      end else begin : g_inner
         assign right_value[i] = cell_value[i+1];
         assign right_scan[i]  = cell_scan[i+1];
      end

      bll_cell #(
         .CW (CW),
         .IDX(i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cell_cmd),
         .pos        (cell_pos),
         .key        (req_value),
         .left_value (left_value[i]),
         .right_value(right_value[i]),
         .right_scan (right_scan[i]),
         .value      (cell_value[i]),
         .scan       (cell_scan[i])
      );
   end

endmodule

// File: tb/bounded_linked_list_engine_test.sv
// Self-checking bench for the bounded linked list engine: directed corner cases, then
// random grow and shrink phases, with a list tracker predicting every result word.
// Depends on bll_pkg and bounded_linked_list_engine from the hdl folder.
module bounded_linked_list_engine_test;
   import bll_pkg::*;

   localparam int CAPACITY = 16;
   localparam int RANDOM_ITEMS = 1750;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int PRESSURE_AT = 200;
   localparam int PRESSURE_CYCLES = 400;

   // Kind codes the block leaves alone; they still give an ok word with zero value
   localparam logic [2:0] KIND_SPARE_LO = 3'd6;
   localparam logic [2:0] KIND_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] value;
   } outcome_type;

   class list_tracker;
      logic [31:0] contents[$];
      outcome_type pending[$];
      int          mismatches;
      int          shown;

      function new();
         mismatches = 0;
         shown = 0;
      endfunction

      task report(string what);
         mismatches++;
         if (shown < 200) begin
            shown++;
            $display("[%0t] mismatch: %s", $realtime, what);
         end
      endtask

      // Apply one accepted request to the tracked list and queue its result word
      function void apply_request(logic [2:0] kind, logic [31:0] value, logic [3:0] position);
         outcome_type o;
         int hit;
         bit full;
         o.status = ST_OK;
         o.value = '0;
         hit = -1;
         full = contents.size() >= CAPACITY;
         case (kind)
            K_INS_FRONT: begin
               if (full) o.status = ST_FULL;
               else begin
                  contents.push_front(value);
                  o.value = value;
               end
            end
            K_INS_LAST: begin
               if (full) o.status = ST_FULL;
               else begin
                  contents.push_back(value);
                  o.value = value;
               end
            end
            K_INS_AFTER: begin
               // empty beats full, full beats range
               if (contents.size() == 0) o.status = ST_EMPTY;
               else if (full) o.status = ST_FULL;
               else if (int'(position) >= contents.size()) o.status = ST_RANGE;
               else begin
                  contents.insert(int'(position) + 1, value);
                  o.value = value;
               end
            end
            K_DEL_FRONT: begin
               if (contents.size() == 0) o.status = ST_EMPTY;
               else o.value = contents.pop_front();
            end
            K_DEL_LAST: begin
               if (contents.size() == 0) o.status = ST_EMPTY;
               else o.value = contents.pop_back();
            end
            K_DEL_VALUE: begin
               if (contents.size() == 0) o.status = ST_EMPTY;
               else begin
                  foreach (contents[i])
                     if (hit < 0 && contents[i] == value) hit = i;
                  if (hit < 0) o.status = ST_NOTFOUND;
                  else begin
                     o.value = contents[hit];
                     contents.delete(hit);
                  end
               end
            end
            default: ;
         endcase
         pending.push_back(o);
      endfunction

      task compare_result(logic [2:0] status, logic [31:0] value);
         outcome_type want;
         if (pending.size() == 0) begin
            report($sformatf("unexpected word, code %0d value %0d", status, $signed(value)));
            return;
         end
         want = pending.pop_front();
         if (status !== want.status)
            report($sformatf("code got %0d want %0d", status, want.status));
         if (value !== want.value)
            report($sformatf("value got %0d want %0d", $signed(value), $signed(want.value)));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // [31:0] value, [35:32] position, [39:36] zero
   logic [2:0]  req_tuser;   // [2:0] kind
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [31:0] result_value
   logic [2:0]  rsp_tuser;   // [2:0] status

   list_tracker tracker;
   bit          sender_gappy;
   bit          receiver_steady;
   int          stall_left;
   int          results_seen;
   int          cycle_count;

   bounded_linked_list_engine #(.CAPACITY(CAPACITY)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", CYCLE_LIMIT);
      $display("status: fail");
      $finish;
   end

   function automatic int sender_gap();
      int r;
      if (!sender_gappy) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [31:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      // narrow range first so duplicates turn up often
      if (r < 5) return 32'($urandom_range(0, 15)) - 32'd8;
      if (r == 5) begin
         case ($urandom_range(0, 3))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hffff_ffff;
         endcase
      end
      return $urandom;
   endfunction

   task automatic pick_request(input bit growing, output logic [2:0] kind,
                               output logic [31:0] value, output logic [3:0] position);
      int r;
      int n;
      n = tracker.contents.size();
      r = $urandom_range(0, 99);
      if (r >= 97) kind = $urandom_range(0, 1) ? KIND_SPARE_HI : KIND_SPARE_LO;
      else if (growing)
         kind = (r < 28) ? K_INS_FRONT : (r < 56) ? K_INS_LAST : (r < 80) ? K_INS_AFTER :
                (r < 86) ? K_DEL_FRONT : (r < 91) ? K_DEL_LAST : K_DEL_VALUE;
      else
         kind = (r < 8) ? K_INS_FRONT : (r < 14) ? K_INS_LAST : (r < 20) ? K_INS_AFTER :
                (r < 45) ? K_DEL_FRONT : (r < 70) ? K_DEL_LAST : K_DEL_VALUE;
      if (kind == K_DEL_VALUE && n > 0 && $urandom_range(0, 9) < 7)
         value = tracker.contents[$urandom_range(0, n - 1)];
      else
         value = pick_value();
      if (n > 0 && $urandom_range(0, 9) < 8) position = 4'($urandom_range(0, n - 1));
      else position = 4'($urandom_range(0, 15));
   endtask

   // Offer one word and hold it until the block takes it
   task automatic send_request(logic [2:0] kind, logic [31:0] value, logic [3:0] position);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0000, position, value};
      do @(posedge clock); while (!req_tready);
      tracker.apply_request(kind, value, position);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
         results_seen = 0;
         receiver_steady = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            tracker.compare_result(rsp_tuser, rsp_tdata);
            results_seen++;
            // long hold-off so the engine backs up into its input
            if (results_seen == PRESSURE_AT) stall_left = PRESSURE_CYCLES;
         end
         if ($urandom_range(0, 299) == 0) receiver_steady = !receiver_steady;
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!receiver_steady) begin
               case ($urandom_range(0, 99)) inside
                  [0:19]:  stall_left = $urandom_range(1, 3);
                  [20:21]: stall_left = $urandom_range(15, 60);
                  default: ;
               endcase
            end
         end
      end
   end

   initial begin : stimulus
      logic [2:0]  k;
      logic [31:0] v;
      logic [3:0]  p;
      bit          growing;
      int          phase_left;

      tracker = new();
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      sender_gappy = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty list, spare kinds, then a short list walked from each end
      send_request(K_DEL_FRONT, 32'd1, 4'd0);
      send_request(K_DEL_LAST, 32'd1, 4'd0);
      send_request(K_DEL_VALUE, 32'd1, 4'd0);
      send_request(K_INS_AFTER, 32'd9, 4'd0);
      send_request(KIND_SPARE_LO, 32'hffff_ffff, 4'd15);
      send_request(KIND_SPARE_HI, 32'h8000_0000, 4'd15);
      send_request(K_INS_FRONT, 32'h7fff_ffff, 4'd15);
      send_request(K_INS_LAST, 32'h8000_0000, 4'd0);
      send_request(K_INS_AFTER, 32'hffff_ffff, 4'd0);
      send_request(K_INS_AFTER, 32'd7, 4'd3);
      send_request(K_INS_AFTER, 32'd7, 4'd15);
      send_request(K_INS_AFTER, 32'd5, 4'd2);
      send_request(K_INS_FRONT, 32'd5, 4'd0);
      send_request(K_DEL_VALUE, 32'd0, 4'd0);
      send_request(K_DEL_VALUE, 32'd5, 4'd0);
      send_request(K_DEL_VALUE, 32'hffff_ffff, 4'd0);
      send_request(K_DEL_VALUE, 32'd5, 4'd0);
      send_request(K_DEL_LAST, 32'd0, 4'd0);
      send_request(K_DEL_FRONT, 32'd0, 4'd0);
      send_request(K_INS_LAST, 32'd0, 4'd0);
      send_request(K_DEL_LAST, 32'd0, 4'd0);

      growing = 1'b0;
      phase_left = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (phase_left == 0) begin
            growing = !growing;
            sender_gappy = ($urandom_range(0, 3) != 0);
            phase_left = $urandom_range(25, 70);
         end
         phase_left--;
         pick_request(growing, k, v, p);
         send_request(k, v, p);
      end
      req_tvalid <= 1'b0;

      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (3 * CAPACITY) @(posedge clock);
      if (tracker.mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
